// ----- design/utf8_accent_folder_assert.svh -----
// assertion helpers shared by the folder modules
`ifndef UTF8_ACCENT_FOLDER_ASSERT_SVH
`define UTF8_ACCENT_FOLDER_ASSERT_SVH

// plain property, sampled on the rising clock edge, off during reset
`define U8AF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication: when ante holds, cons must hold in the same cycle
`define U8AF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- design/u8af_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package u8af_pkg;

   localparam logic [7:0] LEAD_BYTE   = 8'hC3;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_TAG    = 8'h80;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] NO_LETTER   = 8'h00;

   // uppercase base letter by the low five bits of the continuation byte
   localparam logic [7:0] FOLD_UPPER [32] = '{
      8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h00, 8'h00, 8'h43,
      8'h45, 8'h45, 8'h45, 8'h00, 8'h49, 8'h49, 8'h49, 8'h00,
      8'h00, 8'h00, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h00,
      8'h00, 8'h55, 8'h55, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // one word out, or the held lead byte followed by the word
   typedef enum logic {
      OP_ONE,
      OP_PAIR
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data;
      logic        last;
   } fold_op_type;

   function automatic logic [7:0] fold_second(input logic [7:0] b);
      logic [7:0] base;
      base = FOLD_UPPER[b[4:0]];
      if ((b & CONT_MASK) != CONT_TAG) begin
         base = NO_LETTER;
      end else if (base != NO_LETTER && b[5]) begin
         base = base + CASE_OFFSET;
      end
      return base;
   endfunction

endpackage

`default_nettype wire

// ----- design/u8af_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface u8af_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ----- design/u8af_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface u8af_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ----- design/utf8_accent_folder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Folds two-byte UTF-8 accented Latin letters (lead byte 0xC3 followed by one of
// 40 continuation bytes for a, c, e, i, o, u with accent, either case) into the
// plain ASCII letter; every other byte passes through unchanged, a 0xC3 that
// forms no letter is sent on as is, and a 0xC3 pending at a last word is
// flushed. One request word is accepted per cycle while the queue is not full.
// A word that completes a letter or passes through gives one response word; a
// held lead byte and a non-letter give two, but a new non-last lead byte sends
// the old lead alone and is held in turn. Sustained rate is set by the response
// output register; the QUEUE_DEPTH-entry queue between classifier and emitter
// absorbs short bursts of two-word results and response stalls.
module utf8_accent_folder
   import u8af_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic  clock,
   input  wire logic  reset,
   u8af_req_if.sink   req_ch,
   u8af_rsp_if.source rsp_ch
);

   logic        push;
   fold_op_type push_op;
   logic        pop;
   logic        queue_full;
   logic        queue_empty;
   fold_op_type head_op;

   u8af_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_op    (push_op)
   );

   u8af_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .full    (queue_full),
      .empty   (queue_empty),
      .head_op (head_op)
   );

   u8af_back u_back (
      .clock   (clock),
      .reset   (reset),
      .empty   (queue_empty),
      .head_op (head_op),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- design/u8af_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u8af_front
   import u8af_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   u8af_req_if.sink   req,
   input  wire logic  queue_full,
   output logic       push,
   output fold_op_type push_op
);

   logic       lead_ff;
   logic       lead_in;
   logic       accept;
   logic       is_lead;
   logic [7:0] letter;

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;

   always_comb begin
      letter  = fold_second(req.in_byte);
      is_lead = (req.in_byte == LEAD_BYTE);
      push    = 1'b0;
      push_op = '{kind: OP_ONE, data: req.in_byte, last: req.in_last};
      lead_in = lead_ff;
      if (accept) begin
         priority if (lead_ff && letter != NO_LETTER) begin
            push         = 1'b1;
            push_op.data = letter;
            lead_in      = 1'b0;
         end else if (lead_ff && is_lead && !req.in_last) begin
            // old lead goes out alone, new one is held
            push         = 1'b1;
            push_op.data = LEAD_BYTE;
            push_op.last = 1'b0;
            lead_in      = 1'b1;
         end else if (lead_ff) begin
            push         = 1'b1;
            push_op.kind = OP_PAIR;
            lead_in      = 1'b0;
         end else if (is_lead && !req.in_last) begin
            lead_in = 1'b1;
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= 1'b0;
      end else begin
         lead_ff <= lead_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/u8af_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_accent_folder_assert.svh"

module u8af_queue
   import u8af_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire fold_op_type  push_op,
   input  wire logic         pop,
   output logic              full,
   output logic              empty,
   output fold_op_type       head_op
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   fold_op_type   entries_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign head_op = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   `U8AF_ASSERT(a_count_bound, count_ff <= FULL_COUNT, "queue count over depth")
   `U8AF_ASSERT_IMP(a_no_overflow, push, !full, "push into full queue")
   `U8AF_ASSERT_IMP(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

// ----- design/u8af_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_accent_folder_assert.svh"

module u8af_back
   import u8af_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        empty,
   input  wire fold_op_type head_op,
   output logic             pop,
   u8af_rsp_if.source       rsp
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       phase_ff, phase_in;
   logic       slot_free;

   assign slot_free    = !valid_ff || rsp.ready;
   assign rsp.valid    = valid_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.out_last = last_ff;

   always_comb begin
      pop      = 1'b0;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      phase_in = phase_ff;
      if (slot_free) begin
         valid_in = !empty;
         if (!empty) begin
            if (head_op.kind == OP_PAIR && !phase_ff) begin
               // held lead byte first, keep the entry for the second word
               byte_in  = LEAD_BYTE;
               last_in  = 1'b0;
               phase_in = 1'b1;
            end else begin
               byte_in  = head_op.data;
               last_in  = head_op.last;
               phase_in = 1'b0;
               pop      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   `U8AF_ASSERT_IMP(a_phase_on_pair, phase_ff, !empty && head_op.kind == OP_PAIR,
      "second half pending without a pair entry")
   `U8AF_ASSERT_IMP(a_lead_not_last, phase_ff, valid_ff && !last_ff,
      "lead byte of a pair marked last")

endmodule

`default_nettype wire
